### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked assertions with the block's clock and reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/lrb_pkg.sv
// ----------------------------------------------------------------------------
// Line receive buffer package
// Beat types, operation and result codes, and controller/datapath bundles.
// ----------------------------------------------------------------------------
package lrb_pkg;

    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_LINK  = 2'd1;
    localparam logic [1:0] OP_FETCH = 2'd2;
    localparam logic [1:0] OP_POLL  = 2'd3;

    localparam logic [1:0] KIND_ECHO   = 2'd0;
    localparam logic [1:0] KIND_LINE   = 2'd1;
    localparam logic [1:0] KIND_NOLINE = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_OTHER = 3'd1;
    localparam logic [2:0] ERR_FULL  = 3'd2;
    localparam logic [2:0] ERR_LINK  = 3'd3;
    localparam logic [2:0] ERR_BUSY  = 3'd4;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data_byte;
        logic       other_port;
    } t_lrb_in;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [2:0] error_code;
        logic       last;
    } t_lrb_out;

    typedef enum logic [2:0] {
        BSEL_NONE = 3'd0,
        BSEL_DATA = 3'd1,
        BSEL_CR   = 3'd2,
        BSEL_LF   = 3'd3,
        BSEL_CUR  = 3'd4
    } t_byte_sel;

    typedef struct packed {
        logic       wr_en;
        logic       wr_zero;
        logic       wr_at_start;
        logic       fill_inc;
        logic       fill_clr;
        logic       ready_set;
        logic       ready_clr;
        logic       err_set;
        logic [2:0] err_code;
        logic       out_en;
        logic [1:0] out_kind;
        t_byte_sel  out_sel;
        logic       out_code_pend;
        logic       out_last;
        logic       rd_start;
        logic       rd_next;
    } t_lrb_cmd;

    typedef struct packed {
        logic line_ready;
        logic store_full;
        logic err_pending;
        logic is_lf;
        logic is_cr;
        logic rd_zero;
    } t_lrb_status;

endpackage

### hw/rtl/line_receive_buffer_with_echo.sv
// ----------------------------------------------------------------------------
// Line receive buffer with echo
// Collects received serial bytes into a line and plays the line back on fetch.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Received bytes, link
// errors and error polls leave busy low, and any result of theirs appears on
// o_out with o_valid high in the cycle after start. A fetch of a ready line
// holds busy high while it walks the store and, with N the number of stored
// bytes, sends N + 2 result beats (CR echo, LF echo, then the line) on
// consecutive cycles starting the cycle after start; the last beat of a fetch
// or poll has last set. The pace of a fetch is one store read per beat, with
// the registered read running one entry ahead to find the end of the line.
// Each result beat is valid for exactly one cycle and there is no way to hold
// it: the receiver must take every beat as it comes.
`include "assert_macros.svh"

module line_receive_buffer_with_echo #(
    parameter int LINE_DEPTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  lrb_pkg::t_lrb_in  i_in,
    output logic              o_valid,
    output lrb_pkg::t_lrb_out o_out
);

    lrb_pkg::t_lrb_cmd    cmd;
    lrb_pkg::t_lrb_status status;

    lrb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_in     (i_in),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    lrb_dpath #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cmd    (cmd),
        .o_status (status),
        .o_valid  (o_valid),
        .o_out    (o_out)
    );

    `ASSERT_IMPL(a_busy_from_fetch, $rose(busy), $past(start) && ($past(i_in.op) == lrb_pkg::OP_FETCH), "busy rose without a fetch")
    `ASSERT_NEXT(a_fetch_beat_each_cycle, busy, o_valid, "fetch cycle gave no result beat")
    `ASSERT_IMPL(a_fetch_ends_last, $fell(busy), o_valid && o_out.last, "fetch ended without a last beat")
    `ASSERT_IMPL(a_no_write_in_fetch, busy, !cmd.wr_en && !cmd.fill_inc, "store written during a fetch")

endmodule

### hw/rtl/lrb_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/lrb_ctrl.sv
// ----------------------------------------------------------------------------
// Line receive buffer controller
// Decodes each command and sequences the beats of a line fetch.
// ----------------------------------------------------------------------------
module lrb_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  lrb_pkg::t_lrb_in     i_in,
    input  lrb_pkg::t_lrb_status i_status,
    output lrb_pkg::t_lrb_cmd    o_cmd,
    output logic                 o_busy
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LF   = 3'b010,
        S_BYTE = 3'b100
    } t_state;

    t_state            r_state;
    t_state            n_state;
    lrb_pkg::t_lrb_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_in.op)
                        lrb_pkg::OP_BYTE: begin
                            if (i_in.other_port) begin
                                cmd.err_set  = 1'b1;
                                cmd.err_code = lrb_pkg::ERR_OTHER;
                            end else if (i_status.line_ready) begin
                                cmd.err_set  = 1'b1;
                                cmd.err_code = lrb_pkg::ERR_BUSY;
                            end else begin
                                cmd.out_en   = 1'b1;
                                cmd.out_kind = lrb_pkg::KIND_ECHO;
                                cmd.out_sel  = lrb_pkg::BSEL_DATA;
                                if (i_status.is_lf) begin
                                    // Echoed only.
                                end else if (i_status.is_cr) begin
                                    // Terminate the line behind the stored bytes.
                                    cmd.wr_en     = 1'b1;
                                    cmd.wr_zero   = 1'b1;
                                    cmd.ready_set = 1'b1;
                                end else if (i_status.store_full) begin
                                    cmd.wr_en       = 1'b1;
                                    cmd.wr_zero     = 1'b1;
                                    cmd.wr_at_start = 1'b1;
                                    cmd.fill_clr    = 1'b1;
                                    cmd.err_set     = 1'b1;
                                    cmd.err_code    = lrb_pkg::ERR_FULL;
                                end else begin
                                    cmd.wr_en    = 1'b1;
                                    cmd.fill_inc = 1'b1;
                                end
                            end
                        end
                        lrb_pkg::OP_LINK: begin
                            if (!i_in.other_port) begin
                                cmd.fill_clr  = 1'b1;
                                cmd.ready_clr = 1'b1;
                                cmd.err_set   = 1'b1;
                                cmd.err_code  = lrb_pkg::ERR_LINK;
                            end
                        end
                        lrb_pkg::OP_FETCH: begin
                            cmd.out_en = 1'b1;
                            if (!i_status.line_ready) begin
                                cmd.out_kind = lrb_pkg::KIND_NOLINE;
                                cmd.out_sel  = lrb_pkg::BSEL_NONE;
                                cmd.out_last = 1'b1;
                            end else begin
                                cmd.out_kind  = lrb_pkg::KIND_ECHO;
                                cmd.out_sel   = lrb_pkg::BSEL_CR;
                                cmd.rd_start  = 1'b1;
                                cmd.fill_clr  = 1'b1;
                                cmd.ready_clr = 1'b1;
                                n_state       = S_LF;
                            end
                        end
                        lrb_pkg::OP_POLL: begin
                            cmd.out_en        = 1'b1;
                            cmd.out_kind      = lrb_pkg::KIND_ERROR;
                            cmd.out_sel       = lrb_pkg::BSEL_NONE;
                            cmd.out_code_pend = 1'b1;
                            cmd.out_last      = 1'b1;
                            // The store itself is left alone: every byte a fetch
                            // reads is rewritten before the line can close again.
                            if (i_status.err_pending) begin
                                cmd.err_set   = 1'b1;
                                cmd.err_code  = lrb_pkg::ERR_NONE;
                                cmd.fill_clr  = 1'b1;
                                cmd.ready_clr = 1'b1;
                            end
                        end
                        default: begin
                            cmd = '0;
                        end
                    endcase
                end
            end
            S_LF: begin
                // Read data holds entry 0 here; a zero there means an empty line.
                cmd.out_en   = 1'b1;
                cmd.out_kind = lrb_pkg::KIND_ECHO;
                cmd.out_sel  = lrb_pkg::BSEL_LF;
                cmd.out_last = i_status.rd_zero;
                cmd.rd_next  = 1'b1;
                n_state      = i_status.rd_zero ? S_IDLE : S_BYTE;
            end
            S_BYTE: begin
                // The held byte goes out while the next entry is already read,
                // so the last mark is known in the same beat.
                cmd.out_en   = 1'b1;
                cmd.out_kind = lrb_pkg::KIND_LINE;
                cmd.out_sel  = lrb_pkg::BSEL_CUR;
                cmd.out_last = i_status.rd_zero;
                cmd.rd_next  = 1'b1;
                n_state      = i_status.rd_zero ? S_IDLE : S_BYTE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

### hw/rtl/lrb_dpath.sv
// ----------------------------------------------------------------------------
// Line receive buffer datapath
// Line store, fill count, ready flag, pending error and the result register.
// ----------------------------------------------------------------------------
module lrb_dpath #(
    parameter int LINE_DEPTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lrb_pkg::t_lrb_in     i_in,
    input  lrb_pkg::t_lrb_cmd    i_cmd,
    output lrb_pkg::t_lrb_status o_status,
    output logic                 o_valid,
    output lrb_pkg::t_lrb_out    o_out
);

    localparam int AW = $clog2(LINE_DEPTH);

    logic [AW-1:0]     r_fill;
    logic              r_ready;
    logic [2:0]        r_err;
    logic [AW-1:0]     r_idx;
    logic [7:0]        r_cur;
    logic              r_out_vld;
    lrb_pkg::t_lrb_out r_out;
    lrb_pkg::t_lrb_out n_out;

    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    assign wr_addr = i_cmd.wr_at_start ? '0 : r_fill;
    assign wr_data = i_cmd.wr_zero ? 8'h00 : i_in.data_byte;
    assign rd_addr = i_cmd.rd_start ? '0 : r_idx;

    lrb_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_ready   <= 1'b0;
            r_err     <= lrb_pkg::ERR_NONE;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.fill_clr) begin
                r_fill <= '0;
            end else if (i_cmd.fill_inc) begin
                r_fill <= r_fill + AW'(1);
            end
            if (i_cmd.ready_set) begin
                r_ready <= 1'b1;
            end else if (i_cmd.ready_clr) begin
                r_ready <= 1'b0;
            end
            if (i_cmd.err_set) begin
                r_err <= i_cmd.err_code;
            end
            r_out_vld <= i_cmd.out_en;
        end
    end

    // Fetch walk: the index runs one entry ahead of the byte being sent.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_start) begin
            r_idx <= AW'(1);
        end else if (i_cmd.rd_next) begin
            r_idx <= r_idx + AW'(1);
        end
        if (i_cmd.rd_next) begin
            r_cur <= rd_data;
        end
        if (i_cmd.out_en) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        n_out.kind       = i_cmd.out_kind;
        n_out.error_code = i_cmd.out_code_pend ? r_err : lrb_pkg::ERR_NONE;
        n_out.last       = i_cmd.out_last;
        case (i_cmd.out_sel)
            lrb_pkg::BSEL_DATA: n_out.out_byte = i_in.data_byte;
            lrb_pkg::BSEL_CR:   n_out.out_byte = lrb_pkg::CH_CR;
            lrb_pkg::BSEL_LF:   n_out.out_byte = lrb_pkg::CH_LF;
            lrb_pkg::BSEL_CUR:  n_out.out_byte = r_cur;
            default:            n_out.out_byte = 8'h00;
        endcase
    end

    assign o_status.line_ready  = r_ready;
    assign o_status.store_full  = (r_fill == AW'(LINE_DEPTH - 1));
    assign o_status.err_pending = (r_err != lrb_pkg::ERR_NONE);
    assign o_status.is_lf       = (i_in.data_byte == lrb_pkg::CH_LF);
    assign o_status.is_cr       = (i_in.data_byte == lrb_pkg::CH_CR);
    assign o_status.rd_zero     = (rd_data == 8'h00);

    assign o_valid = r_out_vld;
    assign o_out   = r_out;

endmodule

### bench/tb_line_receive_buffer_with_echo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line receive buffer with echo testbench
// Sends received bytes, link errors, line fetches and error polls to the
// block. A scoreboard predicts every echo, line and status beat and checks
// the beats in order as they leave the block.
// ----------------------------------------------------------------------------
module tb_line_receive_buffer_with_echo;

    localparam int DEPTH       = 32;
    localparam int ITEM_TARGET = 410;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 40;

    // Predicts the beats of the line buffer and checks them against the block.
    class line_echo_scoreboard;
        logic [7:0]        line_mem [DEPTH];
        int unsigned       fill;
        bit                ready;
        logic [2:0]        pend_err;
        lrb_pkg::t_lrb_out expected_beats [$];
        int                n_fail;

        function new();
            foreach (line_mem[i]) line_mem[i] = 8'h00;
            fill     = 0;
            ready    = 1'b0;
            pend_err = lrb_pkg::ERR_NONE;
            n_fail   = 0;
        endfunction

        function void push_beat(logic [1:0] kind, logic [7:0] data, logic [2:0] code,
                                logic last);
            lrb_pkg::t_lrb_out beat;
            beat.kind       = kind;
            beat.out_byte   = data;
            beat.error_code = code;
            beat.last       = last;
            expected_beats.push_back(beat);
        endfunction

        function void note_command(lrb_pkg::t_lrb_in cmd);
            int unsigned len;
            case (cmd.op)
                lrb_pkg::OP_BYTE: begin
                    if (cmd.other_port) begin
                        pend_err = lrb_pkg::ERR_OTHER;
                    end else if (ready) begin
                        pend_err = lrb_pkg::ERR_BUSY;
                    end else begin
                        push_beat(lrb_pkg::KIND_ECHO, cmd.data_byte, lrb_pkg::ERR_NONE,
                                  1'b0);
                        if (cmd.data_byte == lrb_pkg::CH_CR) begin
                            if (fill < DEPTH) line_mem[fill] = 8'h00;
                            ready = 1'b1;
                        end else if (cmd.data_byte != lrb_pkg::CH_LF) begin
                            if (fill < DEPTH - 1) begin
                                line_mem[fill] = cmd.data_byte;
                                fill++;
                            end else begin
                                // No room left for the terminator: the line is dropped.
                                fill        = 0;
                                line_mem[0] = 8'h00;
                                pend_err    = lrb_pkg::ERR_FULL;
                            end
                        end
                    end
                end
                lrb_pkg::OP_LINK: begin
                    if (!cmd.other_port) begin
                        fill     = 0;
                        ready    = 1'b0;
                        pend_err = lrb_pkg::ERR_LINK;
                    end
                end
                lrb_pkg::OP_FETCH: begin
                    if (!ready) begin
                        push_beat(lrb_pkg::KIND_NOLINE, 8'h00, lrb_pkg::ERR_NONE, 1'b1);
                    end else begin
                        len = 0;
                        while (len < DEPTH && line_mem[len] != 8'h00) len++;
                        push_beat(lrb_pkg::KIND_ECHO, lrb_pkg::CH_CR, lrb_pkg::ERR_NONE,
                                  1'b0);
                        push_beat(lrb_pkg::KIND_ECHO, lrb_pkg::CH_LF, lrb_pkg::ERR_NONE,
                                  len == 0);
                        for (int unsigned i = 0; i < len; i++)
                            push_beat(lrb_pkg::KIND_LINE, line_mem[i], lrb_pkg::ERR_NONE,
                                      i + 1 == len);
                        fill  = 0;
                        ready = 1'b0;
                    end
                end
                default: begin
                    push_beat(lrb_pkg::KIND_ERROR, 8'h00, pend_err, 1'b1);
                    if (pend_err != lrb_pkg::ERR_NONE) begin
                        pend_err = lrb_pkg::ERR_NONE;
                        fill     = 0;
                        ready    = 1'b0;
                        foreach (line_mem[i]) line_mem[i] = 8'h00;
                    end
                end
            endcase
        endfunction

        function void check_beat(lrb_pkg::t_lrb_out got);
            lrb_pkg::t_lrb_out exp;
            if (expected_beats.size() == 0) begin
                $display("%0t: beat with nothing expected, actual %p", $time, got);
                n_fail++;
                return;
            end
            exp = expected_beats.pop_front();
            if (got.kind !== exp.kind) begin
                $display("%0t: kind mismatch, expected %0d actual %0d",
                         $time, exp.kind, got.kind);
                n_fail++;
            end
            if (got.out_byte !== exp.out_byte) begin
                $display("%0t: out_byte mismatch, expected %02h actual %02h",
                         $time, exp.out_byte, got.out_byte);
                n_fail++;
            end
            if (got.error_code !== exp.error_code) begin
                $display("%0t: error_code mismatch, expected %0d actual %0d",
                         $time, exp.error_code, got.error_code);
                n_fail++;
            end
            if (got.last !== exp.last) begin
                $display("%0t: last mismatch, expected %0b actual %0b",
                         $time, exp.last, got.last);
                n_fail++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    lrb_pkg::t_lrb_in  i_in;
    logic              o_valid;
    lrb_pkg::t_lrb_out o_out;

    line_echo_scoreboard sb;
    int                  cycle_count = 0;
    int                  n_sent = 0;
    int                  idle_pct = 10;

    line_receive_buffer_with_echo #(
        .LINE_DEPTH(DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_in    (i_in),
        .o_valid (o_valid),
        .o_out   (o_out)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Results of a command show up in the cycle after it is taken at the earliest,
    // so the beat is checked before the command of the same edge is noted.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && sb != null) begin
            if (o_valid !== 1'b0) sb.check_beat(o_out);
            if (start === 1'b1 && busy === 1'b0) sb.note_command(i_in);
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    task automatic send_cmd(input logic [1:0] op, input logic [7:0] data,
                            input logic other);
        lrb_pkg::t_lrb_in cmd;
        int               gap;
        cmd.op         = op;
        cmd.data_byte  = data;
        cmd.other_port = other;
        gap = 0;
        if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, 4);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            i_in  <= lrb_pkg::t_lrb_in'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_in  <= cmd;
        do @(posedge i_clk); while (busy !== 1'b0);
        n_sent++;
    endtask

    task automatic send_byte(input logic [7:0] data);
        send_cmd(lrb_pkg::OP_BYTE, data, 1'b0);
    endtask

    // A well-formed line: content bytes, a carriage return, then usually a fetch.
    task automatic send_line();
        int         len;
        logic [7:0] b;
        if ($urandom_range(99) < 85) len = $urandom_range(0, 10);
        else len = $urandom_range(28, 34);
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(0, 255));
            if (b == lrb_pkg::CH_CR) b = 8'h0C;
            if ($urandom_range(99) < 3) b = 8'h00;
            if ($urandom_range(99) < 4) send_cmd(lrb_pkg::OP_BYTE, b, 1'b1);
            else send_byte(b);
        end
        if ($urandom_range(99) < 5) send_cmd(lrb_pkg::OP_LINK, 8'($urandom), 1'b0);
        send_byte(lrb_pkg::CH_CR);
        if ($urandom_range(99) < 15) send_byte(8'($urandom));
        if ($urandom_range(99) < 90)
            send_cmd(lrb_pkg::OP_FETCH, 8'($urandom), 1'($urandom));
        if ($urandom_range(99) < 25)
            send_cmd(lrb_pkg::OP_POLL, 8'($urandom), 1'($urandom));
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_in    = '0;
        sb      = new();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part.
        idle_pct = 0;
        send_cmd(lrb_pkg::OP_POLL, 8'h00, 1'b0);
        send_cmd(lrb_pkg::OP_FETCH, 8'h00, 1'b0);
        send_byte(lrb_pkg::CH_CR);
        send_cmd(lrb_pkg::OP_FETCH, 8'hFF, 1'b1);
        send_byte(8'hFF);
        send_byte(lrb_pkg::CH_LF);
        send_byte(8'h00);
        send_byte(8'h55);
        send_byte(lrb_pkg::CH_CR);
        send_byte(8'h80);
        send_cmd(lrb_pkg::OP_FETCH, 8'h00, 1'b0);
        send_cmd(lrb_pkg::OP_POLL, 8'hFF, 1'b1);
        send_cmd(lrb_pkg::OP_BYTE, 8'hAA, 1'b1);
        send_cmd(lrb_pkg::OP_LINK, 8'h00, 1'b1);
        send_cmd(lrb_pkg::OP_POLL, 8'h00, 1'b0);
        send_byte(8'h01);
        send_cmd(lrb_pkg::OP_LINK, 8'hFF, 1'b0);
        send_cmd(lrb_pkg::OP_POLL, 8'h00, 1'b0);
        send_cmd(lrb_pkg::OP_FETCH, 8'h00, 1'b0);
        send_cmd(lrb_pkg::OP_POLL, 8'h00, 1'b0);

        // Random part, in three idling phases.
        while (n_sent < ITEM_TARGET) begin
            if (n_sent < ITEM_TARGET / 3) idle_pct = 10;
            else if (n_sent < 2 * ITEM_TARGET / 3) idle_pct = 60;
            else idle_pct = 0;
            if ($urandom_range(99) < 75)
                send_line();
            else
                send_cmd(2'($urandom), 8'($urandom), ($urandom_range(99) < 20));
        end
        @(negedge i_clk);
        start <= 1'b0;

        while (sb.expected_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.n_fail == 0 && sb.expected_beats.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### line_receive_buffer_with_echo.f
+incdir+hw/rtl
hw/rtl/lrb_pkg.sv
hw/rtl/lrb_ram.sv
hw/rtl/lrb_ctrl.sv
hw/rtl/lrb_dpath.sv
hw/rtl/line_receive_buffer_with_echo.sv
bench/tb_line_receive_buffer_with_echo.sv
